/* rtl/core/pwm_sup_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pwm_sup_pkg
// Shared widths, register defaults and codes for the PWM inverter supervisor.
// ---------------------------------------------------------------------------
package pwm_sup_pkg;

  // default parameter values
  localparam int PERIOD_BITS_DEF = 16;
  localparam int TEMP_BITS_DEF   = 12;

  // fixed field widths
  localparam int OP_BITS      = 3;
  localparam int AMOUNT_BITS  = 16;
  localparam int CMD_BITS     = 3;
  localparam int MODE_BITS    = 3;
  localparam int CFG_IDX_BITS = 2;

  // configuration register defaults
  localparam int PERIOD_MIN_RST  = 100;
  localparam int PERIOD_MAX_RST  = 10000;
  localparam int PERIOD_INIT_RST = 1000;
  localparam int TEMP_LIMIT_RST  = 3000;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_PERIOD_MIN  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PERIOD_MAX  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PERIOD_INIT = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TEMP_LIMIT  = 2'd3;

  // operation codes
  localparam logic [OP_BITS-1:0] OP_TICK      = 3'd0;
  localparam logic [OP_BITS-1:0] OP_FREQ_UP   = 3'd1;
  localparam logic [OP_BITS-1:0] OP_FREQ_DOWN = 3'd2;
  localparam logic [OP_BITS-1:0] OP_PHASE_UP  = 3'd3;
  localparam logic [OP_BITS-1:0] OP_PHASE_DN  = 3'd4;

  // tick command codes
  localparam logic [CMD_BITS-1:0] CMD_NONE    = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_ENABLE  = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_DISABLE = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_RUN     = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_RESET   = 3'd4;

endpackage

/* rtl/core/pwm_inverter_supervisor_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pwm_inverter_supervisor_core
// Mode sequencing, fault checks and period/phase limiting for a
// phase-shifted PWM inverter, one result per transaction.
// ---------------------------------------------------------------------------
// the result is registered: it appears in the cycle after its input transaction is accepted
// throughput: one transaction per cycle while results are taken, set by the single state update path
// in_tready drops only while a finished result waits on out_tready
// reset (rst_n low, synchronous): mode off, drive disabled, phase zero,
// config registers to defaults, period to the default initial period
module pwm_inverter_supervisor_core #(
  parameter int PERIOD_BITS = pwm_sup_pkg::PERIOD_BITS_DEF,
  parameter int TEMP_BITS   = pwm_sup_pkg::TEMP_BITS_DEF,
  localparam int CFG_BITS   = (PERIOD_BITS > TEMP_BITS) ? PERIOD_BITS : TEMP_BITS,
  localparam int IN_BITS    = ((pwm_sup_pkg::AMOUNT_BITS + pwm_sup_pkg::CMD_BITS + 1
                               + 2 * TEMP_BITS + 7) / 8) * 8,
  localparam int OUT_BITS   = ((pwm_sup_pkg::MODE_BITS + 2 * PERIOD_BITS + 2 + 7) / 8) * 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // amount, command, ext_fault, temp_a, temp_b (lowest bit up)
  input  logic [IN_BITS-1:0]                   in_tdata,
  // operation
  input  logic [pwm_sup_pkg::OP_BITS-1:0]      in_tuser,
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // mode, pwm_period, pwm_phase, drive_enable, clear_pulse, fault_seen
  output logic [OUT_BITS-1:0]                  out_tdata,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pwm_sup_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]                  cfg_data
);

  localparam int AB  = pwm_sup_pkg::AMOUNT_BITS;
  localparam int CB  = pwm_sup_pkg::CMD_BITS;
  localparam int PHB = PERIOD_BITS - 1;
  localparam int AW  = ((PERIOD_BITS > AB) ? PERIOD_BITS : AB) + 1;

  // input field offsets
  localparam int CMD_LO  = AB;
  localparam int EXT_POS = AB + CB;
  localparam int TA_LO   = EXT_POS + 1;
  localparam int TB_LO   = TA_LO + TEMP_BITS;

  typedef enum logic [pwm_sup_pkg::MODE_BITS-1:0] {
    MODE_OFF   = 3'd0,
    MODE_ARMED = 3'd1,
    MODE_RUN   = 3'd2,
    MODE_EXT   = 3'd3,
    MODE_TEMP  = 3'd4
  } mode_t;

  // config registers
  logic [PERIOD_BITS-1:0] period_min_r, period_max_r, period_init_r;
  logic [TEMP_BITS-1:0]   temp_limit_r;

  // supervisor state
  mode_t                  mode_r, mode_nxt;
  logic [PERIOD_BITS-1:0] period_r, period_nxt;
  logic [PHB-1:0]         phase_r, phase_nxt;
  logic                   enable_r, enable_nxt;
  logic                   clear_nxt, seen_nxt;

  // result register
  logic                   out_valid_r;
  mode_t                  out_mode_r;
  logic [PERIOD_BITS-1:0] out_period_r;
  logic [PHB-1:0]         out_phase_r;
  logic                   out_enable_r, out_clear_r, out_seen_r;

  // input fields
  logic [pwm_sup_pkg::OP_BITS-1:0] op;
  logic [AB-1:0]                   amount;
  logic [CB-1:0]                   command;
  logic                            ext_fault;
  logic [TEMP_BITS-1:0]            temp_a, temp_b;
  logic                            in_accept;

  assign op        = in_tuser;
  assign amount    = in_tdata[AB-1:0];
  assign command   = in_tdata[CMD_LO +: CB];
  assign ext_fault = in_tdata[EXT_POS];
  assign temp_a    = in_tdata[TA_LO +: TEMP_BITS];
  assign temp_b    = in_tdata[TB_LO +: TEMP_BITS];

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // fault check
  logic  fault_temp, fault_any;
  mode_t fault_mode;
  assign fault_temp = (temp_a > temp_limit_r) || (temp_b > temp_limit_r);
  assign fault_any  = ext_fault || fault_temp;
  assign fault_mode = ext_fault ? MODE_EXT : MODE_TEMP;

  // adjustment arithmetic
  logic [AW-1:0]          per_w, amt_w, ph_w;
  logic [AW-1:0]          per_sub, per_add, ph_add;
  logic [PHB-1:0]         half;
  logic [PERIOD_BITS-1:0] per_up_q, per_dn_q;
  logic [PHB-1:0]         ph_up_q, ph_dn_q;

  assign per_w   = AW'(period_r);
  assign amt_w   = AW'(amount);
  assign ph_w    = AW'(phase_r);
  assign half    = period_r[PERIOD_BITS-1:1];
  assign per_sub = (per_w > amt_w) ? (per_w - amt_w) : per_w;
  assign per_add = per_w + amt_w;
  assign ph_add  = ph_w + amt_w;

  assign per_up_q = (per_sub < AW'(period_min_r)) ? period_min_r : per_sub[PERIOD_BITS-1:0];
  assign per_dn_q = (period_r >= period_max_r) ? period_r :
                    (per_add > AW'(period_max_r)) ? period_max_r : per_add[PERIOD_BITS-1:0];
  assign ph_up_q  = (ph_add > AW'(half)) ? half : ph_add[PHB-1:0];
  assign ph_dn_q  = (ph_w > amt_w) ? PHB'(ph_w - amt_w) : '0;

  // next state for one transaction
  always_comb begin
    mode_nxt   = mode_r;
    period_nxt = period_r;
    phase_nxt  = phase_r;
    enable_nxt = enable_r;
    clear_nxt  = 1'b0;
    seen_nxt   = 1'b0;
    case (op)
      pwm_sup_pkg::OP_TICK: begin
        case (mode_r)
          MODE_OFF: begin
            enable_nxt = 1'b0;
            period_nxt = period_init_r;
            phase_nxt  = '0;
            if (fault_any) begin
              mode_nxt = fault_mode;
              seen_nxt = 1'b1;
            end else if (command == pwm_sup_pkg::CMD_ENABLE) begin
              enable_nxt = 1'b1;
              mode_nxt   = MODE_ARMED;
            end else if (command == pwm_sup_pkg::CMD_RESET) begin
              clear_nxt = 1'b1;
            end
          end
          MODE_ARMED: begin
            if (fault_any) begin
              mode_nxt = fault_mode;
              seen_nxt = 1'b1;
            end else if (command == pwm_sup_pkg::CMD_DISABLE) begin
              mode_nxt = MODE_OFF;
            end else if (command == pwm_sup_pkg::CMD_RUN) begin
              mode_nxt = MODE_RUN;
            end
          end
          MODE_RUN: begin
            if (fault_any) begin
              mode_nxt = fault_mode;
              seen_nxt = 1'b1;
            end else if (command == pwm_sup_pkg::CMD_DISABLE) begin
              mode_nxt = MODE_OFF;
            end
          end
          MODE_EXT, MODE_TEMP: begin
            enable_nxt = 1'b0;
            if (command == pwm_sup_pkg::CMD_RESET) begin
              clear_nxt = 1'b1;
              if (fault_any) begin
                mode_nxt = fault_mode;
                seen_nxt = 1'b1;
              end else begin
                mode_nxt = MODE_OFF;
              end
            end
          end
          default: mode_nxt = MODE_OFF;
        endcase
      end
      pwm_sup_pkg::OP_FREQ_UP:   if (mode_r == MODE_RUN) period_nxt = per_up_q;
      pwm_sup_pkg::OP_FREQ_DOWN: if (mode_r == MODE_RUN) period_nxt = per_dn_q;
      pwm_sup_pkg::OP_PHASE_UP:  if (mode_r == MODE_RUN) phase_nxt = ph_up_q;
      pwm_sup_pkg::OP_PHASE_DN:  if (mode_r == MODE_RUN) phase_nxt = ph_dn_q;
      default: ;
    endcase
  end

  // config register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_min_r  <= PERIOD_BITS'(pwm_sup_pkg::PERIOD_MIN_RST);
      period_max_r  <= PERIOD_BITS'(pwm_sup_pkg::PERIOD_MAX_RST);
      period_init_r <= PERIOD_BITS'(pwm_sup_pkg::PERIOD_INIT_RST);
      temp_limit_r  <= TEMP_BITS'(pwm_sup_pkg::TEMP_LIMIT_RST);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pwm_sup_pkg::CFG_PERIOD_MIN:  period_min_r  <= cfg_data[PERIOD_BITS-1:0];
        pwm_sup_pkg::CFG_PERIOD_MAX:  period_max_r  <= cfg_data[PERIOD_BITS-1:0];
        pwm_sup_pkg::CFG_PERIOD_INIT: period_init_r <= cfg_data[PERIOD_BITS-1:0];
        pwm_sup_pkg::CFG_TEMP_LIMIT:  temp_limit_r  <= cfg_data[TEMP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // supervisor state and result register on an accepted transaction; valid clears once the result is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_OFF;
      period_r     <= PERIOD_BITS'(pwm_sup_pkg::PERIOD_INIT_RST);
      phase_r      <= '0;
      enable_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      out_mode_r   <= MODE_OFF;
      out_period_r <= '0;
      out_phase_r  <= '0;
      out_enable_r <= 1'b0;
      out_clear_r  <= 1'b0;
      out_seen_r   <= 1'b0;
    end else if (in_accept) begin
      mode_r       <= mode_nxt;
      period_r     <= period_nxt;
      phase_r      <= phase_nxt;
      enable_r     <= enable_nxt;
      out_valid_r  <= 1'b1;
      out_mode_r   <= mode_nxt;
      out_period_r <= period_nxt;
      out_phase_r  <= phase_nxt;
      out_enable_r <= enable_nxt;
      out_clear_r  <= clear_nxt;
      out_seen_r   <= seen_nxt;
    end else if (out_tready) begin
      out_valid_r  <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_BITS'({out_seen_r, out_clear_r, out_enable_r,
                                 out_phase_r, out_period_r, out_mode_r});

  // a transaction always leaves a result behind
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("accepted transaction produced no result");

  // result mirrors the updated state
  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (out_mode_r == mode_r) && (out_period_r == period_r)
                  && (out_phase_r == phase_r) && (out_enable_r == enable_r))
    else $error("result differs from supervisor state");

  // a found fault always lands in a fault mode
  a_seen_in_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_seen_r) |-> (out_mode_r == MODE_EXT || out_mode_r == MODE_TEMP))
    else $error("fault reported outside a fault mode");

  // fault clear only from off or a fault mode
  a_clear_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_clear_r) |->
      (out_mode_r == MODE_OFF || out_mode_r == MODE_EXT || out_mode_r == MODE_TEMP))
    else $error("fault clear in an unexpected mode");

endmodule
